// ===== hw/rtl/wide_binary_to_decimal_digits_macros.svh =====
// Assertion helpers for the checker file.
`ifndef WIDE_BINARY_TO_DECIMAL_DIGITS_MACROS_SVH
`define WIDE_BINARY_TO_DECIMAL_DIGITS_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define WBDD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define WBDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wbdd_pkg.sv =====
package wbdd_pkg;

    localparam int MAX_BYTES  = 32;
    localparam int BYTE_W     = 8;
    localparam int ACC_W      = MAX_BYTES * BYTE_W;
    // decimal digits needed for ACC_W bits: floor(ACC_W * log10(2)) + 1
    localparam int NUM_DIGITS = (ACC_W * 30103) / 100000 + 1;
    localparam int COUNT_W    = $clog2(MAX_BYTES + 2);
    localparam int STEP_W     = (ACC_W > 1) ? $clog2(ACC_W) : 1;
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int CAP_W      = 8;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 8'd100;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_NO_ROOM  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT1,
        CELL_SHIFT2
    } t_cell_op;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_CONVERT,
        S_SKIP,
        S_EMIT,
        S_STATUS
    } t_state;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] digit);
        return ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
    endfunction

endpackage

// ===== hw/rtl/wbdd_cell.sv =====
module wbdd_cell (
    input  logic                          i_clk,
    input  wbdd_pkg::t_cell_op            i_op,
    input  logic                          i_bit,
    input  logic [wbdd_pkg::DIGIT_W-1:0]  i_digit1,
    input  logic [wbdd_pkg::DIGIT_W-1:0]  i_digit2,
    output logic [wbdd_pkg::DIGIT_W-1:0]  o_digit,
    output logic                          o_carry
);
    import wbdd_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    // add-3 correction before the shift
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        unique case (i_op)
            CELL_CLEAR:  n_digit = '0;
            CELL_DABBLE: n_digit = {w_adj[DIGIT_W-2:0], i_bit};
            CELL_SHIFT1: n_digit = i_digit1;
            CELL_SHIFT2: n_digit = i_digit2;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== hw/rtl/wbdd_chain.sv =====
module wbdd_chain (
    input  logic                          i_clk,
    input  wbdd_pkg::t_cell_op            i_op,
    input  logic                          i_bit,
    output logic [wbdd_pkg::DIGIT_W-1:0]  o_top,
    output logic [wbdd_pkg::DIGIT_W-1:0]  o_next
);
    import wbdd_pkg::*;

    logic [DIGIT_W-1:0]    w_digit [NUM_DIGITS];
    logic [NUM_DIGITS-1:0] w_carry;
    logic [NUM_DIGITS-1:0] w_bit_in;

    // cell 0 is the least significant digit
    assign w_bit_in = {w_carry[NUM_DIGITS-2:0], i_bit};

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        logic [DIGIT_W-1:0] w_d1;
        logic [DIGIT_W-1:0] w_d2;

        if (g >= 1) begin : g_d1
            assign w_d1 = w_digit[g-1];
        end else begin : g_d1_zero
            assign w_d1 = '0;
        end

        if (g >= 2) begin : g_d2
            assign w_d2 = w_digit[g-2];
        end else begin : g_d2_zero
            assign w_d2 = '0;
        end

        wbdd_cell u_cell (
            .i_clk    (i_clk),
            .i_op     (i_op),
            .i_bit    (w_bit_in[g]),
            .i_digit1 (w_d1),
            .i_digit2 (w_d2),
            .o_digit  (w_digit[g]),
            .o_carry  (w_carry[g])
        );
    end

    assign o_top  = w_digit[NUM_DIGITS-1];
    assign o_next = w_digit[NUM_DIGITS-2];

endmodule

// ===== hw/rtl/wide_binary_to_decimal_digits.sv =====
// Channel   Direction  Handshake               Payload
// in        sink       i_in_valid/o_in_stall   i_value_byte, i_last_byte
// out       source     o_out_valid/i_out_stall o_first_char, o_second_char,
//                                              o_second_valid, o_last_result, o_status
// cfg       sink       i_cfg_we                i_cfg_data (output_capacity)
//
// A byte that is not last is taken and the input stays open for the next byte. After
// the last byte the digit chain runs shift-and-add-3 over every accumulator bit, then
// drops leading zero digits (up to 77), then checks the capacity, then emits the
// result words one at a time while the sink does not stall.
// Too many bytes: after the last byte, the status word loads once the output is free.
// Input stalls from the last byte until the final result word is registered.
// Reset is synchronous, active low; output_capacity resets to 100.
module wide_binary_to_decimal_digits (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [wbdd_pkg::BYTE_W-1:0]    i_value_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [wbdd_pkg::CHAR_W-1:0]    o_first_char,
    output logic [wbdd_pkg::CHAR_W-1:0]    o_second_char,
    output logic                           o_second_valid,
    output logic                           o_last_result,
    output logic [wbdd_pkg::STATUS_W-1:0]  o_status,
    input  logic                           i_cfg_we,
    input  logic [wbdd_pkg::CAP_W-1:0]     i_cfg_data
);
    import wbdd_pkg::*;

    t_state              r_state, n_state;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [NDIG_W-1:0]   r_ndig, n_ndig;
    t_status             r_status, n_status;
    logic [CAP_W-1:0]    r_cap;

    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_first, n_first;
    logic [CHAR_W-1:0]   r_second, n_second;
    logic                r_sv, n_sv;
    logic                r_last, n_last;
    t_status             r_ostat, n_ostat;

    t_cell_op            w_op;
    logic                w_load;
    logic                w_in_acc;
    logic                w_free;
    logic                w_over;
    logic                w_lead_zero;
    logic                w_no_room;
    logic [DIGIT_W-1:0]  w_top;
    logic [DIGIT_W-1:0]  w_next;

    wbdd_chain u_chain (
        .i_clk  (i_clk),
        .i_op   (w_op),
        .i_bit  (r_acc[ACC_W-1]),
        .o_top  (w_top),
        .o_next (w_next)
    );

    assign o_in_stall  = (r_state != S_COLLECT);
    assign w_in_acc    = i_in_valid && (r_state == S_COLLECT);
    assign w_free      = !r_out_valid || !i_out_stall;
    assign w_over      = (r_count >= COUNT_W'(MAX_BYTES));
    assign w_lead_zero = (w_top == '0) && (r_ndig > NDIG_W'(1));
    assign w_no_room   = (CAP_W'(r_ndig) >= r_cap);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: begin
                if (w_in_acc && i_last_byte) begin
                    n_state = w_over ? S_STATUS : S_CONVERT;
                end
            end
            S_CONVERT: begin
                if (r_step == STEP_W'(ACC_W - 1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (!w_lead_zero) begin
                    n_state = w_no_room ? S_STATUS : S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_free && (r_ndig <= NDIG_W'(2))) begin
                    n_state = S_COLLECT;
                end
            end
            S_STATUS: begin
                if (w_free) begin
                    n_state = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_comb begin
        w_op     = CELL_HOLD;
        w_load   = 1'b0;
        n_acc    = r_acc;
        n_count  = r_count;
        n_step   = r_step;
        n_ndig   = r_ndig;
        n_status = r_status;
        n_first  = '0;
        n_second = '0;
        n_sv     = 1'b0;
        n_last   = 1'b1;
        n_ostat  = r_status;
        unique case (r_state)
            S_COLLECT: begin
                if (w_in_acc) begin
                    if (!w_over) begin
                        n_acc   = {r_acc[ACC_W-BYTE_W-1:0], i_value_byte};
                        n_count = r_count + 1'b1;
                    end else begin
                        n_count = COUNT_W'(MAX_BYTES + 1);
                    end
                    if (i_last_byte) begin
                        n_count = '0;
                        n_step  = '0;
                        n_ndig  = NDIG_W'(NUM_DIGITS);
                        if (w_over) begin
                            n_acc    = '0;
                            n_status = ST_TOO_LONG;
                        end else begin
                            n_status = ST_OK;
                            w_op     = CELL_CLEAR;
                        end
                    end
                end
            end
            S_CONVERT: begin
                w_op   = CELL_DABBLE;
                n_acc  = {r_acc[ACC_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
            end
            S_SKIP: begin
                if (w_lead_zero) begin
                    w_op   = CELL_SHIFT1;
                    n_ndig = r_ndig - 1'b1;
                end else if (w_no_room) begin
                    n_status = ST_NO_ROOM;
                end
            end
            S_EMIT: begin
                n_first  = to_ascii(w_top);
                n_sv     = (r_ndig >= NDIG_W'(2));
                n_second = n_sv ? to_ascii(w_next) : '0;
                n_last   = (r_ndig <= NDIG_W'(2));
                n_ostat  = ST_OK;
                if (w_free) begin
                    w_load = 1'b1;
                    w_op   = CELL_SHIFT2;
                    n_ndig = r_ndig - NDIG_W'(2);
                end
            end
            S_STATUS: begin
                w_load = w_free;
            end
            default: begin
                w_op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_acc       <= '0;
            r_count     <= '0;
            r_step      <= '0;
            r_ndig      <= '0;
            r_status    <= ST_OK;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_count  <= n_count;
            r_step   <= n_step;
            r_ndig   <= n_ndig;
            r_status <= n_status;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_sv     <= n_sv;
            r_last   <= n_last;
            r_ostat  <= n_ostat;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_first_char   = r_first;
    assign o_second_char  = r_second;
    assign o_second_valid = r_sv;
    assign o_last_result  = r_last;
    assign o_status       = r_ostat;

endmodule

// ===== hw/rtl/wbdd_checker.sv =====
`include "wide_binary_to_decimal_digits_macros.svh"

module wbdd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           i_last_byte,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [wbdd_pkg::CHAR_W-1:0]    o_first_char,
    input logic [wbdd_pkg::CHAR_W-1:0]    o_second_char,
    input logic                           o_second_valid,
    input logic                           o_last_result,
    input logic [wbdd_pkg::STATUS_W-1:0]  o_status
);
    import wbdd_pkg::*;

    `WBDD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_first_char) && $stable(o_second_char) && $stable(o_status),
        "stalled output word changed")

    `WBDD_ASSERT_SAME(a_status_word, i_clk, i_rst_n,
        o_out_valid && (o_status != ST_OK),
        (o_first_char == '0) && (o_second_char == '0) && !o_second_valid && o_last_result,
        "status word carries digits or is not last")

    `WBDD_ASSERT_SAME(a_digit_range, i_clk, i_rst_n,
        o_out_valid && (o_status == ST_OK),
        (o_first_char >= ASCII_ZERO) && (o_first_char <= ASCII_ZERO + 6'd9),
        "first char is not an ASCII digit")

    `WBDD_ASSERT_SAME(a_half_word, i_clk, i_rst_n,
        o_out_valid && !o_second_valid,
        (o_second_char == '0) && o_last_result,
        "single-digit word is not the last or has a second char")

    `WBDD_ASSERT_NEXT(a_open_after_byte, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && !i_last_byte,
        !o_in_stall,
        "input closed after a byte that is not last")

endmodule

bind wide_binary_to_decimal_digits wbdd_checker u_wbdd_checker (.*);

// ===== bench/wide_binary_to_decimal_digits_tb.sv =====
`timescale 1ns / 100ps

module wide_binary_to_decimal_digits_tb;
    import wbdd_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 600;

    typedef struct packed {
        logic [CHAR_W-1:0] first_char;
        logic [CHAR_W-1:0] second_char;
        logic              second_valid;
        logic              last_result;
        t_status           status;
    } t_digit_word;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [BYTE_W-1:0]   i_value_byte;
    logic                i_last_byte;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [CHAR_W-1:0]   o_first_char;
    logic [CHAR_W-1:0]   o_second_char;
    logic                o_second_valid;
    logic                o_last_result;
    logic [STATUS_W-1:0] o_status;
    logic                i_cfg_we;
    logic [CAP_W-1:0]    i_cfg_data;

    // predictor state
    logic [ACC_W-1:0]    number_acc;
    int unsigned         bytes_held;
    logic [CAP_W-1:0]    capacity;
    t_digit_word         digit_words_due[$];

    int                  mismatches;
    int                  words_checked;
    int                  status_words;
    int                  numbers_sent;
    int                  bytes_sent;
    int                  idle_pct;
    int                  stall_pct;
    logic                hold_off;

    wide_binary_to_decimal_digits dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value_byte   (i_value_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_first_char   (o_first_char),
        .o_second_char  (o_second_char),
        .o_second_valid (o_second_valid),
        .o_last_result  (o_last_result),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("%0t: timeout, %0d words still due", $time, digit_words_due.size());
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_digit_word got;
        t_digit_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_first_char, o_second_char, o_second_valid, o_last_result,
                    t_status'(o_status)};
            words_checked++;
            if (digit_words_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word first=%0d second=%0d sv=%0b last=%0b st=%0d",
                         $time, got.first_char, got.second_char, got.second_valid,
                         got.last_result, got.status);
            end else begin
                want = digit_words_due.pop_front();
                if (want.status != ST_OK) begin
                    status_words++;
                end
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: mismatch expected first=%0d second=%0d sv=%0b last=%0b st=%0d",
                             $time, want.first_char, want.second_char, want.second_valid,
                             want.last_result, want.status);
                    $display("%0t:          actual first=%0d second=%0d sv=%0b last=%0b st=%0d",
                             $time, got.first_char, got.second_char, got.second_valid,
                             got.last_result, got.status);
                end
            end
        end
    end

    // Shift one byte into the number; on the last byte queue the digit words.
    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [ACC_W-1:0] rest;
        logic [3:0]       digits [NUM_DIGITS];
        int               n;
        t_digit_word      w;
        if (bytes_held < MAX_BYTES) begin
            number_acc = {number_acc[ACC_W-BYTE_W-1:0], b};
            bytes_held++;
        end else begin
            bytes_held = MAX_BYTES + 1;
        end
        if (!last) begin
            return;
        end
        numbers_sent++;
        w = '0;
        w.last_result = 1'b1;
        if (bytes_held > MAX_BYTES) begin
            w.status = ST_TOO_LONG;
            digit_words_due.push_back(w);
        end else begin
            n = 0;
            rest = number_acc;
            do begin
                digits[n] = 4'(rest % 10);
                rest = rest / 10;
                n++;
            end while (rest != 0);
            if (n >= int'(capacity)) begin
                w.status = ST_NO_ROOM;
                digit_words_due.push_back(w);
            end else begin
                for (int hi = n - 1; hi >= 0; hi -= 2) begin
                    w = '0;
                    w.status = ST_OK;
                    w.first_char = ASCII_ZERO + CHAR_W'(digits[hi]);
                    if (hi >= 1) begin
                        w.second_char = ASCII_ZERO + CHAR_W'(digits[hi-1]);
                        w.second_valid = 1'b1;
                    end
                    w.last_result = (hi <= 1);
                    digit_words_due.push_back(w);
                end
            end
        end
        number_acc = '0;
        bytes_held = 0;
    endtask

    // Entered and left at a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_value_byte <= b;
        i_last_byte  <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Low len bytes of v, most significant first; bytes past MAX_BYTES are random.
    task automatic send_value(input logic [ACC_W-1:0] v, input int len);
        for (int i = len - 1; i >= 0; i--) begin
            send_byte(i < MAX_BYTES ? v[i*BYTE_W +: BYTE_W] : BYTE_W'($urandom), i == 0);
        end
    endtask

    function automatic logic [ACC_W-1:0] random_number_bits();
        logic [ACC_W-1:0] v;
        int               pick;
        for (int i = 0; i < MAX_BYTES; i++) begin
            pick = $urandom_range(9);
            v[i*BYTE_W +: BYTE_W] = (pick < 2) ? 8'h00 : (pick == 2) ? 8'hFF
                                                       : BYTE_W'($urandom);
        end
        return v;
    endfunction

    task automatic settle();
        i_in_valid <= 1'b0;
        while (digit_words_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        capacity = v;
    endtask

    // opener: length of a leading number whose top byte is 0xFF, 0 for none
    task automatic run_random(input int target, input int sidle, input int rstall,
                              input logic [CAP_W-1:0] cap, input int opener,
                              input logic long_hold);
        logic [ACC_W-1:0] v;
        int               start;
        int               r;
        int               len;
        write_capacity(cap);
        idle_pct  = sidle;
        stall_pct = rstall;
        if (long_hold) begin
            fork
                begin
                    @(posedge i_clk);
                    hold_off = 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_off = 1'b0;
                end
            join_none
        end
        start = bytes_sent;
        if (opener > 0) begin
            v = random_number_bits();
            v[ACC_W-1 -: BYTE_W] = 8'hFF;
            send_value(v, opener);
        end
        while (bytes_sent - start < target) begin
            r = $urandom_range(99);
            if (r < 65) len = $urandom_range(8, 1);
            else if (r < 83) len = $urandom_range(31, 9);
            else if (r < 92) len = MAX_BYTES;
            else len = $urandom_range(MAX_BYTES + 4, MAX_BYTES + 1);
            send_value(random_number_bits(), len);
        end
    endtask

    task automatic test_short_numbers();
        send_value(256'd0, 1);
        send_value(256'd255, 1);
        send_value(256'd10, 2);
        send_value(256'd0, 3);
        send_value(256'd9999, 2);
        send_value(256'd123456789, 4);
    endtask

    task automatic test_capacity_limits();
        write_capacity(8'd0);
        send_value(256'd7, 1);
        write_capacity(8'd1);
        send_value(256'd0, 1);
        write_capacity(8'd2);
        send_value(256'd9, 1);
        send_value(256'd10, 1);
        write_capacity(8'd4);
        send_value(256'd999, 2);
        send_value(256'd1000, 2);
    endtask

    task automatic test_random_mixes();
        run_random(8, 0, 0, 8'd100, 0, 1'b0);
        run_random(20, 48, 0, 8'd79, MAX_BYTES, 1'b0);
        run_random(20, 0, 48, 8'd78, MAX_BYTES, 1'b0);
        run_random(8, 14, 14, 8'd255, 0, 1'b0);
    endtask

    // The held status word blocks the next number's first word, so the third
    // number waits at the stalled input.
    task automatic test_backpressure();
        run_random(MAX_BYTES + 1, 0, 0, 8'd100, MAX_BYTES + 1, 1'b1);
        send_value(256'd12345, 2);
        send_value(256'd6789, 2);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_value_byte = '0;
        i_last_byte  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        hold_off     = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        number_acc   = '0;
        bytes_held   = 0;
        capacity     = CAP_RESET;
        mismatches   = 0;
        words_checked = 0;
        status_words = 0;
        numbers_sent = 0;
        bytes_sent   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_numbers();
        test_capacity_limits();
        test_random_mixes();
        test_backpressure();
        settle();

        $display("Sent %0d bytes in %0d numbers; checked %0d words, %0d of them status words.",
                 bytes_sent, numbers_sent, words_checked, status_words);
        $display("Capacities 0 to 255, widths up to 36 bytes, idle/stall mixes, long output hold.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
